FILE: design/xlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xlt_pkg
// Shared types, codes and helpers of the table stream parser.
// ----------------------------------------------------------------------------
package xlt_pkg;

    localparam logic [15:0] TAG_TABLE   = 16'd16;
    localparam logic [15:0] HEADER_SIZE = 16'd4;
    localparam logic [15:0] BLANK_BYTES = 16'd2;
    localparam logic [2:0]  FLOAT_LAST  = 3'd7;
    localparam logic [2:0]  WORD_LAST   = 3'd1;
    localparam int          DIV_STEPS   = 17;
    localparam int          DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [15:0] BLK_FLOAT  = 16'd1;
    localparam logic [15:0] BLK_STRING = 16'd2;
    localparam logic [15:0] BLK_BOOL   = 16'd3;
    localparam logic [15:0] BLK_ERROR  = 16'd4;
    localparam logic [15:0] BLK_BLANK  = 16'd5;
    localparam logic [15:0] BLK_INT    = 16'd6;
    localparam logic [15:0] BLK_SKIP   = 16'd7;

    localparam logic [3:0] K_FLOAT = 4'd0;
    localparam logic [3:0] K_CHAR  = 4'd1;
    localparam logic [3:0] K_EMPTY = 4'd2;
    localparam logic [3:0] K_BOOL  = 4'd3;
    localparam logic [3:0] K_ERROR = 4'd4;
    localparam logic [3:0] K_INT   = 4'd5;
    localparam logic [3:0] K_BLANK = 4'd6;
    localparam logic [3:0] K_SIZE  = 4'd7;
    localparam logic [3:0] K_DONE  = 4'd8;
    localparam logic [3:0] K_FAULT = 4'd9;

    localparam logic [2:0] F_NONE      = 3'd0;
    localparam logic [2:0] F_BAD_TAG   = 3'd1;
    localparam logic [2:0] F_BAD_HDR   = 3'd2;
    localparam logic [2:0] F_ZERO_DIM  = 3'd3;
    localparam logic [2:0] F_BAD_SIZE  = 3'd4;
    localparam logic [2:0] F_SKIP      = 3'd5;
    localparam logic [2:0] F_TRUNC     = 3'd6;
    localparam logic [2:0] F_OVERFLOW  = 3'd7;

    typedef enum logic [8:0] {
        PH_HEADER   = 9'b000000001,
        PH_TYPE     = 9'b000000010,
        PH_SIZE     = 9'b000000100,
        PH_FIXED    = 9'b000001000,
        PH_STRLEN   = 9'b000010000,
        PH_STRCHAR  = 9'b000100000,
        PH_BLANK    = 9'b001000000,
        PH_SKIPDATA = 9'b010000000,
        PH_HALT     = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] row;
        logic [15:0] column;
        logic [63:0] value;
        logic        cell_end;
        logic [2:0]  fault_code;
        logic        last_result;
    } t_out_beat;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  bi;
        logic [15:0] btype;
        logic [15:0] blen;
        logic [15:0] bcons;
        logic [63:0] asm_word;
        logic [7:0]  sleft;
        logic [15:0] rows;
        logic [15:0] cols;
        logic [15:0] row;
        logic [15:0] col;
        logic        fault;
    } t_pstate;

    typedef struct packed {
        logic capture;
        logic exec;
        logic mul;
        logic chk;
        logic load;
        logic load_idx;
    } t_cmd;

    typedef struct packed {
        logic       blank;
        logic       any;
        logic [1:0] nres;
        logic       div_go;
        logic       div_done;
        logic       out_free;
    } t_stat;

    localparam t_pstate PSTATE_RESET = '{
        phase: PH_HEADER, bi: 3'd0, btype: 16'd0, blen: 16'd0, bcons: 16'd0,
        asm_word: 64'd0, sleft: 8'd0, rows: 16'd0, cols: 16'd0, row: 16'd0,
        col: 16'd0, fault: 1'b0
    };

    function automatic t_out_beat mk_res(input logic [3:0] kind, input logic [15:0] row,
                                         input logic [15:0] column, input logic [63:0] value,
                                         input logic cell_end, input logic [2:0] code);
        t_out_beat r;
        r.kind        = kind;
        r.row         = row;
        r.column      = column;
        r.value       = value;
        r.cell_end    = cell_end;
        r.fault_code  = code;
        r.last_result = 1'b0;
        return r;
    endfunction

endpackage

FILE: design/xlt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xlt_div
// Restoring divider, one quotient bit per cycle, for blank-run positions.
// ----------------------------------------------------------------------------
module xlt_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [16:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [16:0] o_quot,
    output logic [15:0] o_rem
);
    import xlt_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [16:0]          r_q, n_q;
    logic [15:0]          r_rem, n_rem;
    logic [15:0]          r_dvs;
    logic [16:0]          trial;
    logic                 ge;

    always_comb begin
        trial  = {r_rem, r_q[16]};
        ge     = trial >= {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_q   = {r_q[15:0], ge};
            n_rem = ge ? 16'(trial - {1'b0, r_dvs}) : trial[15:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

FILE: design/xlt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xlt_datapath
// Parse state, per-byte decode, blank-run check and output register.
// ----------------------------------------------------------------------------
module xlt_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xlt_pkg::t_in_beat i_in_data,
    input  xlt_pkg::t_cmd     i_cmd,
    output xlt_pkg::t_stat    o_stat,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output xlt_pkg::t_out_beat o_out_data
);
    import xlt_pkg::*;

    t_pstate   r_st;
    logic [7:0] r_byte;
    logic      r_last;
    logic [15:0] r_count;
    logic [31:0] r_pstart, r_pcells;
    t_out_beat r_res0, r_res1;
    logic [1:0] r_nres;
    t_out_beat r_out;
    logic      r_out_valid;

    t_pstate   e_st, c_st;
    t_out_beat h_res, l_res, e_res0, e_res1, c_res0, c_res1;
    logic      h_v, l_v, h_flt, e_blank;
    logic [2:0] h_fcode;
    logic [1:0] e_nres, c_nres;
    logic [63:0] sh, asm_h;
    logic [16:0] col_inc;
    logic [15:0] adv_row, adv_col, cons, new_len, new_type;
    logic        blk_end, ovf_row;
    logic [2:0]  last_i;
    logic [33:0] chk_sum;
    logic        c_ovf, c_div_go;
    logic        div_done;
    logic [16:0] div_quot;
    logic [15:0] div_rem;
    logic        out_free;

    // per-byte decode
    always_comb begin
        e_st    = r_st;
        h_v     = 1'b0;
        h_res   = '0;
        l_v     = 1'b0;
        l_res   = '0;
        h_flt   = 1'b0;
        h_fcode = F_NONE;
        e_blank = 1'b0;
        sh      = {56'd0, r_byte} << {r_st.bi, 3'b000};
        asm_h   = r_st.asm_word | sh;
        col_inc = {1'b0, r_st.col} + 17'd1;
        if (col_inc >= {1'b0, r_st.cols}) begin
            adv_col = '0;
            adv_row = r_st.row + 16'd1;
        end else begin
            adv_col = col_inc[15:0];
            adv_row = r_st.row;
        end
        cons     = (r_st.bcons == 16'hFFFF) ? r_st.bcons : r_st.bcons + 16'd1;
        blk_end  = cons >= r_st.blen;
        ovf_row  = r_st.row >= r_st.rows;
        new_len  = {r_byte, r_st.blen[7:0]};
        new_type = {r_byte, r_st.btype[7:0]};
        last_i   = (r_st.btype == BLK_FLOAT) ? FLOAT_LAST : WORD_LAST;
        if (!r_st.fault) begin
            case (r_st.phase)
                PH_HEADER: begin
                    e_st.asm_word = asm_h;
                    if (r_st.bi == 3'd1 && asm_h[15:0] != TAG_TABLE) begin
                        h_flt = 1'b1; h_fcode = F_BAD_TAG;
                    end else if (r_st.bi == 3'd3 && asm_h[31:16] != HEADER_SIZE) begin
                        h_flt = 1'b1; h_fcode = F_BAD_HDR;
                    end else if (r_st.bi == 3'd7) begin
                        e_st.rows = asm_h[47:32];
                        e_st.cols = asm_h[63:48];
                        if (asm_h[47:32] == 16'd0 || asm_h[63:48] == 16'd0) begin
                            h_flt = 1'b1; h_fcode = F_ZERO_DIM;
                        end else begin
                            h_v   = 1'b1;
                            h_res = mk_res(K_SIZE, asm_h[47:32], asm_h[63:48], 64'd0,
                                           1'b0, F_NONE);
                            e_st.phase    = PH_TYPE;
                            e_st.bi       = 3'd0;
                            e_st.asm_word = '0;
                            e_st.row      = '0;
                            e_st.col      = '0;
                        end
                    end else begin
                        e_st.bi = r_st.bi + 3'd1;
                    end
                end
                PH_TYPE: begin
                    if (r_st.bi == 3'd0) begin
                        e_st.btype = {8'd0, r_byte};
                        e_st.bi    = 3'd1;
                    end else begin
                        e_st.btype = new_type;
                        e_st.bi    = 3'd0;
                        if (new_type == BLK_SKIP) begin
                            h_flt = 1'b1; h_fcode = F_SKIP;
                        end else begin
                            e_st.phase = PH_SIZE;
                        end
                    end
                end
                PH_SIZE: begin
                    if (r_st.bi == 3'd0) begin
                        e_st.blen = {8'd0, r_byte};
                        e_st.bi   = 3'd1;
                    end else begin
                        e_st.blen     = new_len;
                        e_st.bi       = 3'd0;
                        e_st.bcons    = '0;
                        e_st.asm_word = '0;
                        e_st.sleft    = '0;
                        if ((r_st.btype == BLK_FLOAT && new_len[2:0] != 3'd0) ||
                            ((r_st.btype == BLK_BOOL || r_st.btype == BLK_ERROR ||
                              r_st.btype == BLK_INT) && new_len[0]) ||
                            (r_st.btype == BLK_BLANK && new_len != BLANK_BYTES)) begin
                            h_flt = 1'b1; h_fcode = F_BAD_SIZE;
                        end else if (r_st.btype == BLK_BLANK) begin
                            e_st.phase = PH_BLANK;
                        end else if (new_len == 16'd0) begin
                            e_st.phase = PH_TYPE;
                        end else if (r_st.btype == BLK_FLOAT || r_st.btype == BLK_BOOL ||
                                     r_st.btype == BLK_ERROR || r_st.btype == BLK_INT) begin
                            e_st.phase = PH_FIXED;
                        end else if (r_st.btype == BLK_STRING) begin
                            e_st.phase = PH_STRLEN;
                        end else begin
                            e_st.phase = PH_SKIPDATA;
                        end
                    end
                end
                PH_FIXED: begin
                    e_st.asm_word = asm_h;
                    e_st.bcons    = cons;
                    if (r_st.bi < last_i) begin
                        e_st.bi = r_st.bi + 3'd1;
                    end else begin
                        e_st.bi = 3'd0;
                        if (ovf_row) begin
                            h_flt = 1'b1; h_fcode = F_OVERFLOW;
                        end else begin
                            h_v = 1'b1;
                            if (r_st.btype == BLK_FLOAT) begin
                                h_res = mk_res(K_FLOAT, r_st.row, r_st.col, asm_h, 1'b0, F_NONE);
                            end else if (r_st.btype == BLK_BOOL) begin
                                h_res = mk_res(K_BOOL, r_st.row, r_st.col,
                                               {63'd0, asm_h != 64'd0}, 1'b0, F_NONE);
                            end else if (r_st.btype == BLK_ERROR) begin
                                h_res = mk_res(K_ERROR, r_st.row, r_st.col, asm_h, 1'b0, F_NONE);
                            end else begin
                                h_res = mk_res(K_INT, r_st.row, r_st.col, asm_h, 1'b0, F_NONE);
                            end
                            e_st.asm_word = '0;
                            e_st.row      = adv_row;
                            e_st.col      = adv_col;
                            if (blk_end) begin
                                e_st.phase = PH_TYPE;
                            end
                        end
                    end
                end
                PH_STRLEN: begin
                    e_st.bcons = cons;
                    if (ovf_row) begin
                        h_flt = 1'b1; h_fcode = F_OVERFLOW;
                    end else if (r_byte == 8'd0) begin
                        h_v      = 1'b1;
                        h_res    = mk_res(K_EMPTY, r_st.row, r_st.col, 64'd0, 1'b0, F_NONE);
                        e_st.row = adv_row;
                        e_st.col = adv_col;
                        if (blk_end) begin
                            e_st.phase = PH_TYPE;
                            e_st.bi    = 3'd0;
                        end
                    end else begin
                        e_st.sleft = r_byte;
                        e_st.phase = PH_STRCHAR;
                    end
                end
                PH_STRCHAR: begin
                    e_st.bcons = cons;
                    e_st.sleft = r_st.sleft - 8'd1;
                    h_v        = 1'b1;
                    h_res      = mk_res(K_CHAR, r_st.row, r_st.col, {56'd0, r_byte},
                                        r_st.sleft == 8'd1, F_NONE);
                    if (r_st.sleft == 8'd1) begin
                        e_st.row   = adv_row;
                        e_st.col   = adv_col;
                        e_st.phase = PH_STRLEN;
                        if (blk_end) begin
                            e_st.phase = PH_TYPE;
                            e_st.bi    = 3'd0;
                        end
                    end
                end
                PH_BLANK: begin
                    if (r_st.bi == 3'd0) begin
                        e_st.asm_word = {56'd0, r_byte};
                        e_st.bi       = 3'd1;
                    end else begin
                        e_blank       = 1'b1;
                        e_st.bi       = 3'd0;
                        e_st.asm_word = '0;
                    end
                end
                PH_SKIPDATA: begin
                    e_st.bcons = cons;
                    if (blk_end) begin
                        e_st.phase = PH_TYPE;
                        e_st.bi    = 3'd0;
                    end
                end
                default: begin
                end
            endcase
        end
        if (h_flt) begin
            h_v        = 1'b1;
            h_res      = mk_res(K_FAULT, 16'd0, 16'd0, 64'd0, 1'b0, h_fcode);
            e_st.fault = 1'b1;
            e_st.phase = PH_HALT;
        end
        if (r_last && !e_blank) begin
            if (!e_st.fault) begin
                l_v = 1'b1;
                if (e_st.phase == PH_TYPE && e_st.bi == 3'd0) begin
                    l_res = mk_res(K_DONE, 16'd0, 16'd0, 64'd0, 1'b0, F_NONE);
                end else begin
                    l_res = mk_res(K_FAULT, 16'd0, 16'd0, 64'd0, 1'b0, F_TRUNC);
                end
            end
            e_st = PSTATE_RESET;
        end
        e_nres = {1'b0, h_v} + {1'b0, l_v};
        e_res0 = h_v ? h_res : l_res;
        e_res1 = l_res;
        if (e_nres == 2'd1) begin
            e_res0.last_result = 1'b1;
        end
        if (e_nres == 2'd2) begin
            e_res1.last_result = 1'b1;
        end
    end

    // blank-run range check
    always_comb begin
        c_st    = r_st;
        chk_sum = {2'b00, r_pstart} + {18'd0, r_st.col} + {18'd0, r_count};
        c_ovf   = (r_count != 16'd0) && (chk_sum > {2'b00, r_pcells});
        if (c_ovf) begin
            c_res0     = mk_res(K_FAULT, 16'd0, 16'd0, 64'd0, 1'b0, F_OVERFLOW);
            c_st.fault = 1'b1;
            c_st.phase = PH_HALT;
        end else begin
            c_res0     = mk_res(K_BLANK, r_st.row, r_st.col, {48'd0, r_count}, 1'b0, F_NONE);
            c_st.phase = PH_TYPE;
        end
        c_res1 = mk_res(K_DONE, 16'd0, 16'd0, 64'd0, 1'b0, F_NONE);
        c_nres = 2'd1;
        if (r_last) begin
            if (!c_ovf) begin
                c_nres = 2'd2;
            end
            c_st = PSTATE_RESET;
        end
        if (c_nres == 2'd1) begin
            c_res0.last_result = 1'b1;
        end else begin
            c_res1.last_result = 1'b1;
        end
        c_div_go = !c_ovf && !r_last && (r_count != 16'd0);
    end

    xlt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.chk && c_div_go),
        .i_dividend ({1'b0, r_st.col} + {1'b0, r_count}),
        .i_divisor  (r_st.cols),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= PSTATE_RESET;
            r_nres      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_st   <= e_st;
                r_nres <= e_nres;
            end else if (i_cmd.chk) begin
                r_st   <= c_st;
                r_nres <= c_nres;
            end else if (div_done) begin
                r_st.row <= r_st.row + div_quot[15:0];
                r_st.col <= div_rem;
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_byte <= i_in_data.data_byte;
            r_last <= i_in_data.last_byte;
        end
        if (i_cmd.exec) begin
            r_res0 <= e_res0;
            r_res1 <= e_res1;
            if (e_blank) begin
                r_count <= {r_byte, r_st.asm_word[7:0]};
            end
        end
        if (i_cmd.chk) begin
            r_res0 <= c_res0;
            r_res1 <= c_res1;
        end
        if (i_cmd.mul) begin
            r_pstart <= r_st.row * r_st.cols;
            r_pcells <= r_st.rows * r_st.cols;
        end
        if (i_cmd.load) begin
            r_out <= i_cmd.load_idx ? r_res1 : r_res0;
        end
    end

    assign o_stat.blank    = e_blank;
    assign o_stat.any      = e_nres != 2'd0;
    assign o_stat.nres     = r_nres;
    assign o_stat.div_go   = c_div_go;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = out_free;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

FILE: design/xlt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xlt_ctrl
// Sequencer: accept a byte, decode it, run the blank-run check, emit beats.
// ----------------------------------------------------------------------------
module xlt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  xlt_pkg::t_stat i_stat,
    output xlt_pkg::t_cmd  o_cmd
);
    import xlt_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EXEC = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_CHK  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_EMIT = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_idx, n_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.blank) begin
                    n_state = ST_MUL;
                end else if (i_stat.any) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_CHK;
            end
            ST_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = i_stat.div_go ? ST_DIV : ST_EMIT;
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.load_idx = r_idx;
                    if (r_idx || i_stat.nres == 2'd1) begin
                        n_idx   = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_in_stall = r_state != ST_IDLE;

`ifndef SYNTHESIS
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid) |=> (r_state == ST_EXEC))
        else $error("accepted beat not decoded next cycle");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_stat.out_free)
        else $error("output register overwritten while stalled");
    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && !i_stat.div_done) |=> (r_state == ST_DIV))
        else $error("left divide wait before done");
`endif

endmodule

FILE: design/xltable_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xltable_stream_parser
// Byte-serial parser of a spreadsheet-table message into cell result beats.
// ----------------------------------------------------------------------------
// Input channel: one message byte per beat, with last_byte on the final one.
// Output channel: cell, size, done and fault beats with row and column.
// A byte is taken only while the parser is idle; each byte is captured and
// decoded, then emits up to two result beats, which wait while the receiver stalls.
// A blank-run block's count byte also runs a multiply step and a range check;
// if not last, a non-empty in-range run waits on the divider to move the position.
// The output register holds a beat while the receiver stalls; the parser
// waits for it and accepts no byte until all beats of the current byte left.
// After a fault, bytes are dropped up to last_byte. After last_byte, and at
// reset, the parser expects a new header; reset also empties the output.
// ----------------------------------------------------------------------------
module xltable_stream_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  xlt_pkg::t_in_beat   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output xlt_pkg::t_out_beat  o_out_data
);
    import xlt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    xlt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    xlt_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
